// File: hdl/ned_pkg.sv
// ----------------------------------------------------------------------------
// ned_pkg
// Shared constants and types for the nearest event distance block.
// ----------------------------------------------------------------------------
package ned_pkg;

  localparam int EVENT_DEPTH_DEFAULT = 1024;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  localparam logic [31:0] DIST_MAX = 32'hFFFF_FFFF;

  // Request to the shared divider and its status.
  typedef struct packed {
    logic        start;
    logic [47:0] num;
    logic [32:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;

endpackage

// File: hdl/ned_ram.sv
// ----------------------------------------------------------------------------
// ned_ram
// Generic simple dual-port RAM with one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ned_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/ned_div.sv
// ----------------------------------------------------------------------------
// ned_div
// Restoring divider, one quotient bit per cycle, saturating at 32 bits.
// ----------------------------------------------------------------------------
module ned_div (
  input  logic              clk,
  input  logic              rst,
  input  ned_pkg::div_req_t req,
  output ned_pkg::div_rsp_t rsp
);

  logic [47:0] quo;
  logic [32:0] rem;
  logic [32:0] den;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [33:0] trial;

  assign trial = {rem, quo[47]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
        quo  <= req.num;
        den  <= req.den;
        rem  <= '0;
      end else if (busy) begin
        if (trial[33]) begin
          rem <= {rem[31:0], quo[47]};
          quo <= {quo[46:0], 1'b0};
        end else begin
          rem <= trial[32:0];
          quo <= {quo[46:0], 1'b1};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd47) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = (quo[47:32] != 16'd0) ? ned_pkg::DIST_MAX : quo[31:0];

endmodule

// File: hdl/nearest_event_distance.sv
// ----------------------------------------------------------------------------
// nearest_event_distance
// Bisection over a sorted event table and distance to the nearer neighbor.
// ----------------------------------------------------------------------------
// Clear and append transfers are taken in S_IDLE and do not leave it. A query
// holds the input through setup, up to log2(depth) bisection probes, and up to
// two candidates, each with a division in relative mode when its gap is nonzero.
// A last query after a held one adds a second job for its own result.
// A result waits in the output register; the input stalls once the next is ready.
// Synchronous reset empties the table and drops any held query.
module nearest_event_distance #(
  parameter int EVENT_DEPTH = ned_pkg::EVENT_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // action[1:0], time_value[33:2], zero pad
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // distance[31:0], position[47:32]
  output logic        m_tlast    // final_res
);

  localparam int AW = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
  localparam int CW = $clog2(EVENT_DEPTH + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SETUP = 4'd1;
  localparam logic [3:0] S_PROBE = 4'd2;
  localparam logic [3:0] S_WAIT  = 4'd3;
  localparam logic [3:0] S_CMP   = 4'd4;
  localparam logic [3:0] S_RDA   = 4'd5;
  localparam logic [3:0] S_WTA   = 4'd6;
  localparam logic [3:0] S_EVA   = 4'd7;
  localparam logic [3:0] S_DIVA  = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  localparam logic [1:0] RULE_FIRST  = 2'd0;
  localparam logic [1:0] RULE_MIDDLE = 2'd1;
  localparam logic [1:0] RULE_LAST   = 2'd2;

  logic [3:0]  state;
  logic        relative_mode;
  logic [CW-1:0] event_count;
  logic [31:0] held_time;
  logic [31:0] before_held_time;
  logic [15:0] query_count;
  logic        pending;

  // Current evaluation job.
  logic [31:0] q_time;     // query being evaluated
  logic [31:0] g_prev;     // gap partner for event j
  logic [31:0] g_next;     // gap partner for event j+1
  logic [1:0]  rule;
  logic        second;     // job is the final second result
  logic [31:0] last_time;  // the final query held for the second result
  logic [15:0] out_pos;
  logic        out_fin;
  logic        cand;       // 0 evaluating event j, 1 event j+1
  logic [31:0] best;
  logic [CW-1:0] lo;
  logic [CW-1:0] up;
  logic [CW-1:0] mid;

  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;
  logic [AW-1:0] raddr_reg;

  ned_pkg::div_req_t dreq;
  ned_pkg::div_rsp_t drsp;

  logic [1:0]  in_action;
  logic [31:0] in_time;
  logic        acc_in;

  assign in_action = s_tdata[1:0];
  assign in_time   = s_tdata[33:2];
  assign s_tready  = (state == S_IDLE) && !second;
  assign acc_in    = s_tvalid && s_tready;
  assign ram_we    = acc_in && (in_action == ned_pkg::ACT_APPEND)
                     && (event_count < CW'(EVENT_DEPTH));

  ned_ram #(.WIDTH(32), .DEPTH(EVENT_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (event_count[AW-1:0]),
    .wdata (in_time),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ned_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  assign ram_raddr = raddr_reg;

  // Shared magnitude/compare datapath.
  logic signed [32:0] ev_s;
  logic signed [32:0] qt_s;
  logic signed [32:0] gp_s;
  logic signed [33:0] dif_e;
  logic signed [33:0] dif_g;
  logic [31:0] mag;
  logic [32:0] gap;
  logic [31:0] cand_val;

  assign ev_s  = {ram_rdata[31], ram_rdata};
  assign qt_s  = {q_time[31], q_time};
  assign gp_s  = cand ? {g_next[31], g_next} : {g_prev[31], g_prev};
  assign dif_e = qt_s - ev_s;
  assign dif_g = qt_s - gp_s;
  assign mag   = dif_e[33] ? 32'(-dif_e) : dif_e[31:0];
  assign gap   = dif_g[33] ? 33'(-dif_g) : dif_g[32:0];

  always_comb begin
    dreq.start = 1'b0;
    dreq.num   = {mag, 16'd0};
    dreq.den   = gap;
    if (state == S_EVA && relative_mode && gap != 33'd0) begin
      dreq.start = 1'b1;
    end
  end

  always_comb begin
    if (!relative_mode) begin
      cand_val = mag;
    end else begin
      cand_val = ned_pkg::DIST_MAX;
    end
  end

  logic [31:0] res_val;
  assign res_val = (state == S_DIVA) ? drsp.quo : cand_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      relative_mode    <= 1'b0;
      event_count      <= '0;
      held_time        <= '0;
      before_held_time <= '0;
      query_count      <= '0;
      pending          <= 1'b0;
      m_tvalid         <= 1'b0;
      second           <= 1'b0;
    end else begin
      if (cfg_we) begin
        relative_mode <= cfg_wdata;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (second) begin
            // Final query of the stream, against the last event.
            second  <= 1'b0;
            q_time  <= last_time;
            g_prev  <= held_time;
            rule    <= RULE_LAST;
            out_pos <= query_count;
            out_fin <= 1'b1;
            pending          <= 1'b0;
            query_count      <= '0;
            held_time        <= '0;
            before_held_time <= '0;
            state   <= S_SETUP;
          end else if (acc_in) begin
            unique case (in_action)
              ned_pkg::ACT_CLEAR: event_count <= '0;
              ned_pkg::ACT_APPEND: begin
                if (event_count < CW'(EVENT_DEPTH)) begin
                  event_count <= event_count + CW'(1);
                end
              end
              ned_pkg::ACT_QUERY: begin
                if (!pending) begin
                  query_count <= '0;
                  if (s_tlast) begin
                    q_time  <= in_time;
                    g_prev  <= in_time;
                    rule    <= RULE_LAST;
                    out_pos <= '0;
                    out_fin <= 1'b1;
                    state   <= S_SETUP;
                  end else begin
                    held_time <= in_time;
                    pending   <= 1'b1;
                  end
                end else begin
                  q_time  <= held_time;
                  g_prev  <= before_held_time;
                  g_next  <= in_time;
                  rule    <= (query_count == 16'd0) ? RULE_FIRST : RULE_MIDDLE;
                  out_pos <= query_count;
                  out_fin <= 1'b0;
                  query_count <= query_count + 16'd1;
                  if (s_tlast) begin
                    second    <= 1'b1;
                    last_time <= in_time;
                  end else begin
                    before_held_time <= held_time;
                    held_time        <= in_time;
                  end
                  state <= S_SETUP;
                end
              end
              default: ;
            endcase
          end
        end
        S_SETUP: begin
          // The first-query rule looks only at event 0 with the next-query gap.
          cand <= (rule == RULE_FIRST);
          best <= ned_pkg::DIST_MAX;
          lo   <= '0;
          up   <= event_count;
          if (event_count == '0) begin
            state <= S_EMIT;
          end else if (rule == RULE_FIRST) begin
            raddr_reg <= '0;
            state     <= S_WTA;
          end else if (rule == RULE_LAST) begin
            raddr_reg <= AW'(event_count - CW'(1));
            state     <= S_WTA;
          end else begin
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          mid       <= CW'((lo + up) >> 1);
          raddr_reg <= AW'((lo + up) >> 1);
          state     <= S_WAIT;
        end
        S_WAIT: state <= S_CMP;
        S_CMP: begin
          // Bisection step: lo/up narrow until they differ by one.
          if ($signed(q_time) >= $signed(ram_rdata)) begin
            lo <= mid;
            if (up - mid <= CW'(1)) begin
              state <= S_RDA;
            end else begin
              state <= S_PROBE;
            end
          end else begin
            up <= mid;
            if (mid - lo <= CW'(1)) begin
              state <= S_RDA;
            end else begin
              state <= S_PROBE;
            end
          end
        end
        S_RDA: begin
          raddr_reg <= AW'(lo) + AW'(cand);
          state     <= S_WTA;
        end
        S_WTA: state <= S_EVA;
        S_EVA: begin
          if (relative_mode && gap != 33'd0) begin
            state <= S_DIVA;
          end else begin
            if (cand_val < best) best <= cand_val;
            state <= S_DIVA;
          end
        end
        S_DIVA: begin
          if (!relative_mode || gap == 33'd0 || drsp.done) begin
            if (relative_mode && drsp.done && res_val < best) begin
              best <= res_val;
            end
            // Middle rule goes on to event j+1 unless j is the table end.
            if (rule == RULE_MIDDLE && !cand && (lo + CW'(1) < event_count)) begin
              cand  <= 1'b1;
              state <= S_RDA;
            end else begin
              state <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {out_pos, best};
            m_tlast  <= out_fin;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Input is only accepted while the sequencer is idle.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (acc_in |-> state == S_IDLE))
    else $error("input accepted while busy");

  // Divider only runs while the sequencer waits on it.
  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    (drsp.busy |-> state == S_DIVA))
    else $error("divider busy outside divide wait");

  // Table count never exceeds the depth.
  a_count: assert property (@(posedge clk) disable iff (rst)
    (event_count <= CW'(EVENT_DEPTH)))
    else $error("event count overflow");

endmodule
